// ----- rtl/r2a_pkg.sv -----
// ----------------------------------------------------------------------------
// r2a_pkg
// Types, constants and helpers shared by the radix integer-to-ascii block.
// ----------------------------------------------------------------------------
`default_nettype none

package r2a_pkg;

    // width of the number field; the payload struct takes its number width from it
    localparam int NUMBER_BITS = 16;
    localparam int BIT_CNT_W   = $clog2(NUMBER_BITS);
    localparam int DIG_IDX_W   = $clog2(NUMBER_BITS);
    localparam int DIG_CNT_W   = $clog2(NUMBER_BITS + 1);

    localparam logic [5:0] RADIX_MIN  = 6'd2;
    localparam logic [5:0] RADIX_MAX  = 6'd36;
    localparam logic [5:0] DIGIT_NINE = 6'd9;
    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A    = 7'h61;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] number;
        logic [5:0]             radix;
    } t_in;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic radix_ok;
        logic bit_last;
        logic quot_zero;
        logic out_free;
        logic cnt_one;
    } t_status;

    function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
        logic [6:0] c;
        if (d > DIGIT_NINE) begin
            c = {1'b0, d} - 7'd10 + ASCII_A;
        end else begin
            c = {1'b0, d} + ASCII_ZERO;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/r2a_ctrl.sv -----
// ----------------------------------------------------------------------------
// r2a_ctrl
// Sequencer: load, per-digit bit-serial division, digit store, then output.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_ctrl
    import r2a_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_status i_status,
    output logic         o_ready,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_STORE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                // an item with a bad radix is taken and dropped
                if (i_valid && i_status.radix_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.bit_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (i_status.quot_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/r2a_datapath.sv -----
// ----------------------------------------------------------------------------
// r2a_datapath
// Restoring divider by the radix, digit buffer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_datapath
    import r2a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_in   i_in,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_ready,
    output t_status    o_status,
    output logic       o_valid,
    output t_out       o_out
);

    logic [NUMBER_BITS-1:0] r_value, n_value;
    logic [5:0]             r_radix, n_radix;
    logic [5:0]             r_rem, n_rem;
    logic [BIT_CNT_W-1:0]   r_bit, n_bit;
    logic [DIG_CNT_W-1:0]   r_count, n_count;
    logic [6:0]             r_digits [NUMBER_BITS];
    logic                   r_valid, n_valid;
    t_out                   r_out, n_out;

    logic [6:0]           trial;
    logic                 ge;
    logic [DIG_CNT_W-1:0] count_m1;

    // one quotient bit per cycle
    assign trial    = {r_rem, r_value[NUMBER_BITS-1]};
    assign ge       = trial >= {1'b0, r_radix};
    assign count_m1 = r_count - DIG_CNT_W'(1);

    assign o_status.radix_ok  = (i_in.radix >= RADIX_MIN) && (i_in.radix <= RADIX_MAX);
    assign o_status.bit_last  = r_bit == BIT_CNT_W'(NUMBER_BITS - 1);
    assign o_status.quot_zero = r_value == '0;
    assign o_status.out_free  = !r_valid || i_ready;
    assign o_status.cnt_one   = r_count == DIG_CNT_W'(1);

    always_comb begin
        n_value = r_value;
        n_radix = r_radix;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_count = r_count;
        n_out   = r_out;
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_cmd.load) begin
            n_value = i_in.number;
            n_radix = i_in.radix;
            n_rem   = '0;
            n_bit   = '0;
            n_count = '0;
        end
        if (i_cmd.step) begin
            n_value = {r_value[NUMBER_BITS-2:0], ge};
            n_rem   = ge ? 6'(trial - {1'b0, r_radix}) : trial[5:0];
            n_bit   = r_bit + BIT_CNT_W'(1);
        end
        if (i_cmd.store) begin
            n_rem   = '0;
            n_bit   = '0;
            n_count = r_count + DIG_CNT_W'(1);
        end
        if (i_cmd.emit) begin
            n_out.character = r_digits[count_m1[DIG_IDX_W-1:0]];
            n_out.last      = r_count == DIG_CNT_W'(1);
            n_count         = count_m1;
            n_valid         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_bit   <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_bit   <= n_bit;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_radix <= n_radix;
        r_rem   <= n_rem;
        r_out   <= n_out;
        if (i_cmd.store) begin
            r_digits[r_count[DIG_IDX_W-1:0]] <= digit_to_ascii(r_rem);
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    // never overwrite a digit the receiver has not taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_valid || i_ready))
        else $error("emit while output register busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DIG_CNT_W'(NUMBER_BITS))
        else $error("digit count overflow");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_count != '0))
        else $error("emit from empty digit buffer");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> ((r_out.character >= ASCII_ZERO && r_out.character <= 7'h39)
            || (r_out.character >= ASCII_A && r_out.character <= 7'h7a)))
        else $error("character out of digit range");

endmodule

`default_nettype wire

// ----- rtl/radix_integer_to_ascii.sv -----
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Converts an unsigned number to ascii digits in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries i_in (number, radix). Output channel
// o_valid/i_ready carries o_out (character, last), one transfer per digit,
// most significant digit first; last marks the final digit. Zero gives '0'.
// An item whose radix lies outside 2 to 36 is taken and produces nothing.
// Each digit is worked out by the bit-serial restoring divider, which steps
// through all NUMBER_BITS bits of the value, and is then stored in the digit
// buffer, so the work on an item grows with its number of digits.
// One item is worked on at a time; o_ready is high only between items, and
// a new item can be taken while the final digit still waits at the output.
// If the receiver stalls, the output register holds its digit and the
// sequencer waits before moving the next one out.
// Synchronous active-low reset empties the output register and returns the
// sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_to_ascii
    import r2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_in,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_out
);

    t_cmd    cmd;
    t_status status;

    r2a_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    r2a_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .i_ready  (i_ready),
        .o_status (status),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radix_integer_to_ascii. Every accepted number is
// expanded into its expected digit characters by a scoreboard. Each digit
// transfer on the output is compared with the oldest expected digit. A short
// directed part covers zero, full scale, the smallest and largest radix and
// rejected radix values. Random numbers follow in four idling phases, with
// one long receiver hold that backs the block up into its input.
// ----------------------------------------------------------------------------

module tb_top;
    import r2a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 320;
    localparam int PHASE_ITEMS = 85;
    localparam int HOLD_CYCLES = 600;
    localparam int NUM_DIRECTED = 22;

    class digit_scoreboard;
        t_out awaited_digits[$];
        int   mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            mismatch_count++;
        endtask

        // digits of one number, most significant first; rejected radix gives none
        function void note_item(input t_in item);
            string digit_set;
            int    value;
            int    base;
            t_out  digit;
            t_out  run[$];
            digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
            value = int'(item.number);
            base  = int'(item.radix);
            if (base < int'(RADIX_MIN) || base > int'(RADIX_MAX)) begin
                return;
            end
            do begin
                digit.character = 7'(digit_set[value % base]);
                digit.last      = 1'b0;
                run.push_front(digit);
                value = value / base;
            end while (value != 0);
            run[run.size() - 1].last = 1'b1;
            foreach (run[k]) begin
                awaited_digits.push_back(run[k]);
            end
        endfunction

        task check_digit(input t_out got);
            t_out want;
            if (awaited_digits.size() == 0) begin
                report_mismatch("unexpected transfer", int'(got), 0);
                return;
            end
            want = awaited_digits.pop_front();
            if (got.character !== want.character) begin
                report_mismatch("character", int'(got.character), int'(want.character));
            end
            if (got.last !== want.last) begin
                report_mismatch("last", int'(got.last), int'(want.last));
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_in    = '0;
    logic o_ready;
    logic o_valid;
    t_out o_out;

    digit_scoreboard sb;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_len     = 0;
    int hold_token   = 0;
    int hold_taken   = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    t_in directed_items [NUM_DIRECTED] = '{
        '{16'd0,     6'd2},
        '{16'd0,     6'd36},
        '{16'd65535, 6'd2},
        '{16'd65535, 6'd36},
        '{16'd65535, 6'd10},
        '{16'd65535, 6'd16},
        '{16'd1,     6'd2},
        '{16'd35,    6'd36},
        '{16'd36,    6'd36},
        '{16'd9,     6'd10},
        '{16'd10,    6'd11},
        '{16'd65535, 6'd0},
        '{16'd0,     6'd1},
        '{16'd65535, 6'd37},
        '{16'd12345, 6'd63},
        '{16'h5555,  6'd3},
        '{16'haaaa,  6'd7},
        '{16'd255,   6'd16},
        '{16'd256,   6'd16},
        '{16'd12345, 6'd10},
        '{16'd46655, 6'd36},
        '{16'd32768, 6'd2}
    };

    radix_integer_to_ascii u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_token != hold_taken) begin
            hold_taken <= hold_token;
            hold_left  <= hold_len - 1;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_digit(o_out);
        end
    end

    task send_item(input t_in item);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= item;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sb.note_item(item);
        @(negedge i_clk);
    endtask

    task wait_all_digits();
        i_valid <= 1'b0;
        while (sb.awaited_digits.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    function automatic t_in random_item(input bit rejected);
        t_in item;
        int  base;
        int  power;
        int  pick;
        if (rejected) begin
            pick = $urandom_range(0, 28);
            item.radix  = (pick < 2) ? 6'(pick) : 6'(35 + pick);
            item.number = 16'($urandom);
            return item;
        end
        case ($urandom_range(0, 5))
            0:       base = 2;
            1:       base = 36;
            2:       base = ($urandom_range(0, 1) != 0) ? 10 : 16;
            default: base = $urandom_range(2, 36);
        endcase
        item.radix = 6'(base);
        case ($urandom_range(0, 9))
            0: item.number = 16'd0;
            1: item.number = 16'hffff;
            2: item.number = 16'($urandom_range(0, 40));
            3: begin
                // land on or just below a power of the radix
                power = 1;
                repeat ($urandom_range(1, 15)) begin
                    if (power * base <= 65535) begin
                        power = power * base;
                    end
                end
                item.number = 16'(power - $urandom_range(0, 1));
            end
            default: item.number = 16'($urandom);
        endcase
        return item;
    endfunction

    task run_random(input int count);
        int  sent;
        bit  rejected;
        sent = 0;
        while (sent < count) begin
            rejected = ($urandom_range(99) < 6);
            send_item(random_item(rejected));
            if (!rejected) begin
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_items[k]) begin
            send_item(directed_items[k]);
        end
        wait_all_digits();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    // output held off long enough for the input to back up
                    hold_len   = HOLD_CYCLES;
                    hold_token = hold_token + 1;
                end
                1: begin
                    tx_idle_pct  = 51;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 51;
                end
                default: begin
                    tx_idle_pct  = 19;
                    rx_stall_pct = 19;
                end
            endcase
            run_random(PHASE_ITEMS);
            wait_all_digits();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.awaited_digits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- radix_integer_to_ascii.f -----
rtl/r2a_pkg.sv
rtl/r2a_ctrl.sv
rtl/r2a_datapath.sv
rtl/radix_integer_to_ascii.sv
verif/tb_top.sv
